[rtl/disk_mask_nonmax_suppressor_assert.svh]
// assertion macros for the suppressor
`ifndef DISK_MASK_NONMAX_SUPPRESSOR_ASSERT_SVH
`define DISK_MASK_NONMAX_SUPPRESSOR_ASSERT_SVH

`define DMNS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define DMNS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[rtl/dmns_pkg.sv]
`default_nettype none
package dmns_pkg;
    localparam int MASK_W_DEF       = 64;
    localparam int MASK_H_DEF       = 64;
    localparam int SCALE_LEVELS_DEF = 4;
    localparam int MAX_RES_DEF      = 7;

    localparam logic [2:0] REG_INV_CELL   = 3'd0;
    localparam logic [2:0] REG_OFFSET_X   = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd2;
    localparam logic [2:0] REG_RESOLUTION = 3'd3;
    localparam logic [2:0] REG_LOG2_BASE  = 3'd4;

    localparam logic FUNC_TEST  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef struct packed {
        logic [15:0]        inv_cell;
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic [2:0]         resolution;
        logic signed [7:0]  log2_base;
    } cfg_t;
endpackage
`default_nettype wire

[rtl/dmns_if.sv]
`default_nettype none
interface dmns_in_if;
    logic              valid;
    logic              ready;
    logic              func;
    logic [15:0]       loc_x;
    logic [15:0]       loc_y;
    logic signed [7:0] scale_log2;
    modport source (output valid, func, loc_x, loc_y, scale_log2, input ready);
    modport sink (input valid, func, loc_x, loc_y, scale_log2, output ready);
endinterface

interface dmns_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] level_used;
    logic       clamped;
    modport source (output valid, accepted, level_used, clamped, input ready);
    modport sink (input valid, accepted, level_used, clamped, output ready);
endinterface

interface dmns_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/disk_mask_nonmax_suppressor.sv]
// channel | dir | request
// cfg     | in  | index, data
// in      | in  | func, loc_x, loc_y, scale_log2
// out     | out | accepted, level_used, clamped
// test: S_CALC, S_READ, S_TEST, where a covered point ends; a stamped one goes on through
// S_OUT and S_STAMP (one mask row a cycle, rows cy-r to cy+r), r being the radius after
// saturation; the waiting result holds off the next request
// clear: one memory row a cycle; it also runs from reset, before any request is taken
// a waiting result blocks only the next request, not configuration
`default_nettype none
module disk_mask_nonmax_suppressor
    import dmns_pkg::*;
#(
    parameter int MASK_W       = MASK_W_DEF,
    parameter int MASK_H       = MASK_H_DEF,
    parameter int SCALE_LEVELS = SCALE_LEVELS_DEF,
    parameter int MAX_RES      = MAX_RES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    dmns_cfg_if.sink cfg,
    dmns_in_if.sink  in_ch,
    dmns_out_if.source out_ch
);
    `include "disk_mask_nonmax_suppressor_assert.svh"

    localparam int XW    = $clog2(MASK_W);
    localparam int YW    = $clog2(MASK_H);
    localparam int LW    = (SCALE_LEVELS > 1) ? $clog2(SCALE_LEVELS) : 1;
    localparam int DEPTH = SCALE_LEVELS * MASK_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RES + 1) + 1;
    localparam int JW    = RW + 1;
    localparam int YYW   = ((YW > JW) ? YW : JW) + 2;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CALC, S_READ, S_TEST, S_STAMP, S_OUT}
        state_t;

    state_t state_reg;
    cfg_t   cfg_reg;
    logic [AW-1:0] clr_reg;
    logic clr_cmd_reg;
    logic [7:0] stamp_reg;
    logic [15:0] lx_reg, ly_reg;
    logic signed [7:0] sl_reg;
    logic signed [JW-1:0] j_reg;
    logic [RW-1:0] rad_reg;
    logic acc_reg, clamp_reg, oval_reg;
    logic [1:0] lvu_reg;
    logic [LW-1:0] lvl_reg;
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;

    logic [LW-1:0] lvl_c;
    logic [XW-1:0] cx_c;
    logic [YW-1:0] cy_c;
    logic clamp_c;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [MASK_W-1:0] wdata, rdata, disk_row;
    logic signed [YYW-1:0] yy;
    logic [2*JW+1:0] rr, jj;

    dmns_cell_calc #(.MASK_W(MASK_W), .MASK_H(MASK_H), .SCALE_LEVELS(SCALE_LEVELS)) u_calc (
        .clk(clk), .cfg(cfg_reg), .start(state_reg == S_CALC),
        .loc_x(lx_reg), .loc_y(ly_reg), .scale_log2(sl_reg),
        .level(lvl_c), .cell_x(cx_c), .cell_y(cy_c), .clamped(clamp_c)
    );

    dmns_ram #(.WIDTH(MASK_W), .DEPTH(DEPTH)) u_mask (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (state_reg == S_IDLE) && !oval_reg;
    assign out_ch.valid      = oval_reg;
    assign out_ch.accepted   = acc_reg;
    assign out_ch.level_used = lvu_reg;
    assign out_ch.clamped    = clamp_reg;

    assign yy = YYW'($signed({1'b0, cy_reg})) + YYW'(j_reg);
    assign rr = (2*JW+2)'(rad_reg) * (2*JW+2)'(rad_reg);
    assign jj = (2*JW+2)'(j_reg) * (2*JW+2)'(j_reg);

    // row of the disk at offset j: bits with |x-cx| <= floor(sqrt(r^2 - j^2))
    always_comb
    begin
        int dx;
        int rem;
        int hw;
        rem = int'(rr) - int'(jj);
        hw  = 0;
        for (int w = 1; w <= MAX_RES; w++)
        begin
            if (w * w <= rem)
            begin
                hw = w;
            end
        end
        disk_row = '0;
        for (int x = 0; x < MASK_W; x++)
        begin
            dx = x - int'(cx_reg);
            if (rem >= 0 && dx <= hw && dx >= -hw)
            begin
                disk_row[x] = 1'b1;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(lvl_reg) * AW'(MASK_H) + AW'(yy);
        wdata = rdata | disk_row;
        raddr = AW'(lvl_reg) * AW'(MASK_H) + AW'(cy_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
            end
            S_READ:
            begin
                raddr = AW'(lvl_c) * AW'(MASK_H) + AW'(cy_c);
            end
            S_STAMP:
            begin
                we = (yy >= 0) && (yy < YYW'(MASK_H));
                if (yy + 1 >= 0 && yy + 1 < YYW'(MASK_H))
                begin
                    raddr = AW'(lvl_reg) * AW'(MASK_H) + AW'(yy + 1);
                end
            end
            S_OUT:
            begin
                raddr = AW'(lvl_reg) * AW'(MASK_H) + AW'(yy);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            clr_cmd_reg <= 1'b0;
            stamp_reg   <= '0;
            oval_reg    <= 1'b0;
            cfg_reg     <= '{inv_cell: 16'd256, offset_x: '0, offset_y: '0,
                             resolution: 3'd3, log2_base: '0};
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_INV_CELL:   cfg_reg.inv_cell   <= cfg.data[15:0];
                    REG_OFFSET_X:   cfg_reg.offset_x   <= cfg.data[23:0];
                    REG_OFFSET_Y:   cfg_reg.offset_y   <= cfg.data[23:0];
                    REG_RESOLUTION: cfg_reg.resolution <= cfg.data[2:0];
                    REG_LOG2_BASE:  cfg_reg.log2_base  <= cfg.data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (32'(clr_reg) == DEPTH - 1)
                    begin
                        state_reg   <= S_IDLE;
                        clr_reg     <= '0;
                        clr_cmd_reg <= 1'b0;
                        if (clr_cmd_reg)
                        begin
                            oval_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        if (in_ch.func == FUNC_CLEAR)
                        begin
                            state_reg   <= S_CLEAR;
                            clr_cmd_reg <= 1'b1;
                            stamp_reg   <= '0;
                            acc_reg     <= 1'b0;
                            lvu_reg     <= '0;
                            clamp_reg   <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_CALC;
                            lx_reg    <= in_ch.loc_x;
                            ly_reg    <= in_ch.loc_y;
                            sl_reg    <= in_ch.scale_log2;
                            j_reg     <= '0;
                        end
                    end
                end
                S_CALC:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    lvl_reg   <= lvl_c;
                    cx_reg    <= cx_c;
                    cy_reg    <= cy_c;
                    clamp_reg <= clamp_c;
                    lvu_reg   <= 2'(lvl_c);
                    rad_reg   <= (32'(cfg_reg.resolution) > MAX_RES) ? RW'(MAX_RES)
                                 : RW'(cfg_reg.resolution);
                    j_reg     <= '0;
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (rdata[cx_reg])
                    begin
                        acc_reg   <= 1'b0;
                        oval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        acc_reg   <= 1'b1;
                        j_reg     <= -$signed({1'b0, rad_reg});
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_STAMP;
                end
                S_STAMP:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (j_reg == $signed({1'b0, rad_reg}))
                    begin
                        stamp_reg <= stamp_reg + 1'b1;
                        oval_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `DMNS_ASSERT_IMP(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `DMNS_ASSERT_IMP(a_ready_no_out, clk, rst_n, in_ch.ready, !oval_reg)
    `DMNS_ASSERT_NXT(a_test_done, clk, rst_n, state_reg == S_TEST && rdata[cx_reg],
        oval_reg && !acc_reg)
endmodule
`default_nettype wire

[rtl/dmns_ram.sv]
`default_nettype none
module dmns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/dmns_cell_calc.sv]
`default_nettype none
module dmns_cell_calc
    import dmns_pkg::*;
#(
    parameter int MASK_W       = MASK_W_DEF,
    parameter int MASK_H       = MASK_H_DEF,
    parameter int SCALE_LEVELS = SCALE_LEVELS_DEF,
    localparam int XW = $clog2(MASK_W),
    localparam int YW = $clog2(MASK_H),
    localparam int LW = (SCALE_LEVELS > 1) ? $clog2(SCALE_LEVELS) : 1
) (
    input  wire logic              clk,
    input  wire cfg_t              cfg,
    input  wire logic              start,
    input  wire logic [15:0]       loc_x,
    input  wire logic [15:0]       loc_y,
    input  wire logic signed [7:0] scale_log2,
    output logic [LW-1:0]          level,
    output logic [XW-1:0]          cell_x,
    output logic [YW-1:0]          cell_y,
    output logic                   clamped
);
    // stage 1: products, offset and level; stage 2: shift, resolution add, clamp
    logic signed [41:0] qx_reg, qy_reg;
    logic [LW-1:0]      lvl_reg;
    logic               lclamp_reg;
    logic signed [8:0]  dl;
    logic signed [4:0]  lraw;
    logic [31:0]        px, py;
    logic signed [29:0] cx, cy;
    logic               cxl, cxh, cyl, cyh;

    assign dl   = 9'(scale_log2) - 9'(cfg.log2_base);
    assign lraw = dl[8:4];
    assign px   = loc_x * cfg.inv_cell;
    assign py   = loc_y * cfg.inv_cell;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg <= $signed({10'd0, px}) + 42'(cfg.offset_x) * 42'sd16;
            qy_reg <= $signed({10'd0, py}) + 42'(cfg.offset_y) * 42'sd16;
            if (lraw < 0)
            begin
                lvl_reg    <= '0;
                lclamp_reg <= 1'b1;
            end
            else if (32'(lraw) > SCALE_LEVELS - 1)
            begin
                lvl_reg    <= LW'(SCALE_LEVELS - 1);
                lclamp_reg <= 1'b1;
            end
            else
            begin
                lvl_reg    <= LW'(lraw);
                lclamp_reg <= 1'b0;
            end
        end
    end

    assign cx = 30'((qx_reg >>> 12) >>> lvl_reg) + 30'(cfg.resolution);
    assign cy = 30'((qy_reg >>> 12) >>> lvl_reg) + 30'(cfg.resolution);
    assign cxl = cx < 0;
    assign cxh = cx > 30'(MASK_W - 1);
    assign cyl = cy < 0;
    assign cyh = cy > 30'(MASK_H - 1);

    always_comb
    begin
        level   = lvl_reg;
        cell_x  = cxl ? '0 : (cxh ? XW'(MASK_W - 1) : cx[XW-1:0]);
        cell_y  = cyl ? '0 : (cyh ? YW'(MASK_H - 1) : cy[YW-1:0]);
        clamped = lclamp_reg | cxl | cxh | cyl | cyh;
    end
endmodule
`default_nettype wire

[tb/tb_disk_mask_nonmax_suppressor.sv]
`timescale 1ns / 100ps
module tb_disk_mask_nonmax_suppressor;
    import dmns_pkg::*;

    localparam int GRID_W = MASK_W_DEF;
    localparam int GRID_H = MASK_H_DEF;
    localparam int LEVELS = SCALE_LEVELS_DEF;
    localparam int RAD_MAX = MAX_RES_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic       accepted;
        logic [1:0] level_used;
        logic       clamped;
    } verdict_t;

    typedef struct {
        logic              func;
        logic [15:0]       loc_x;
        logic [15:0]       loc_y;
        logic signed [7:0] scale_log2;
        logic              known;
        verdict_t          res;
    } row_t;

    logic clk;
    logic rst_n;

    dmns_cfg_if cfg ();
    dmns_in_if  in_ch ();
    dmns_out_if out_ch ();

    disk_mask_nonmax_suppressor dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // predictor state
    logic [GRID_W-1:0] cover_map [LEVELS][GRID_H];
    logic [15:0] m_inv_cell;
    logic signed [23:0] m_off_x;
    logic signed [23:0] m_off_y;
    logic [2:0] m_res;
    logic signed [7:0] m_log2_base;

    verdict_t verdict_q[$];
    int mismatches;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    bit timed_out;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint floor_div_pow2(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint cell_index(logic [15:0] loc, logic signed [23:0] off,
                                          int lvl);
        longint q;
        q = longint'(loc) * longint'(m_inv_cell) + longint'(off) * 16;
        return floor_div_pow2(floor_div_pow2(q, 12), lvl) + longint'(m_res);
    endfunction

    function automatic verdict_t suppress_feature(row_t r);
        verdict_t v;
        longint lvl, cx, cy;
        int rad, y, x;
        v = '0;
        if (r.func == FUNC_CLEAR)
        begin
            foreach (cover_map[l, h])
                cover_map[l][h] = '0;
            return v;
        end
        lvl = floor_div_pow2(longint'(r.scale_log2) - longint'(m_log2_base), 4);
        if (lvl < 0)
        begin
            lvl = 0;
            v.clamped = 1'b1;
        end
        else if (lvl > LEVELS - 1)
        begin
            lvl = LEVELS - 1;
            v.clamped = 1'b1;
        end
        cx = cell_index(r.loc_x, m_off_x, int'(lvl));
        cy = cell_index(r.loc_y, m_off_y, int'(lvl));
        if (cx < 0 || cx > GRID_W - 1)
        begin
            cx = (cx < 0) ? 0 : GRID_W - 1;
            v.clamped = 1'b1;
        end
        if (cy < 0 || cy > GRID_H - 1)
        begin
            cy = (cy < 0) ? 0 : GRID_H - 1;
            v.clamped = 1'b1;
        end
        v.level_used = lvl[1:0];
        if (!cover_map[lvl][cy][cx])
        begin
            v.accepted = 1'b1;
            rad = (m_res > RAD_MAX) ? RAD_MAX : int'(m_res);
            for (int j = -rad; j <= rad; j++)
            begin
                y = int'(cy) + j;
                if (y < 0 || y >= GRID_H)
                    continue;
                for (int i = -rad; i <= rad; i++)
                begin
                    x = int'(cx) + i;
                    if (x >= 0 && x < GRID_W && i * i + j * j <= rad * rad)
                        cover_map[lvl][y][x] = 1'b1;
                end
            end
        end
        return v;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_INV_CELL:   m_inv_cell = val[15:0];
            REG_OFFSET_X:   m_off_x = val[23:0];
            REG_OFFSET_Y:   m_off_y = val[23:0];
            REG_RESOLUTION: m_res = val[2:0];
            REG_LOG2_BASE:  m_log2_base = val[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_empty();
        in_ch.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic drain_results();
        wait_empty();
        repeat (40)
            @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] ic, logic [23:0] ox, logic [23:0] oy,
                              logic [2:0] rs, logic [7:0] smin);
        drain_results();
        write_reg(REG_INV_CELL, {16'd0, ic});
        write_reg(REG_OFFSET_X, {8'd0, ox});
        write_reg(REG_OFFSET_Y, {8'd0, oy});
        write_reg(REG_RESOLUTION, {29'd0, rs});
        write_reg(REG_LOG2_BASE, {24'd0, smin});
        cfg.valid <= 1'b0;
    endtask

    task automatic send_feature(row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= r.func;
        in_ch.loc_x <= r.loc_x;
        in_ch.loc_y <= r.loc_y;
        in_ch.scale_log2 <= r.scale_log2;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (r.known)
            void'(suppress_feature(r));
        verdict_q.insert(verdict_q.size(), r.known ? r.res : suppress_feature(r));
    endtask

    function automatic row_t mk(logic f, logic [15:0] lx, logic [15:0] ly,
                                logic [7:0] s);
        row_t r;
        r.func = f;
        r.loc_x = lx;
        r.loc_y = ly;
        r.scale_log2 = s;
        r.known = 1'b0;
        r.res = '0;
        return r;
    endfunction

    function automatic row_t mk_known(logic f, logic [15:0] lx, logic [15:0] ly,
                                      logic [7:0] s, verdict_t v);
        row_t r;
        r = mk(f, lx, ly, s);
        r.known = 1'b1;
        r.res = v;
        return r;
    endfunction

    function automatic row_t rand_feature(bit cluster);
        row_t r;
        r = mk(FUNC_TEST, 16'($urandom), 16'($urandom), 8'($urandom));
        if (cluster)
        begin
            r.loc_x = 16'($urandom_range(1023));
            r.loc_y = 16'($urandom_range(1023));
            r.scale_log2 = 8'($urandom_range(0, 70));
        end
        if ($urandom_range(59) == 0)
            r.func = FUNC_CLEAR;
        return r;
    endfunction

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
            if (out_ch.valid && out_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected request: %b %0d %b", out_ch.accepted,
                                 out_ch.level_used, out_ch.clamped);
                end
                else
                begin
                    verdict_t e;
                    e = verdict_q.pop_front();
                    if (e.accepted !== out_ch.accepted || e.level_used !== out_ch.level_used
                        || e.clamped !== out_ch.clamped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %b %0d %b, got %b %0d %b",
                                     e.accepted, e.level_used, e.clamped, out_ch.accepted,
                                     out_ch.level_used, out_ch.clamped);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        row_t dir_rows[$];
        verdict_t v0;
        mismatches = 0;
        idle_cycles = 0;
        recv_hold = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 65;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_TEST;
        in_ch.loc_x = '0;
        in_ch.loc_y = '0;
        in_ch.scale_log2 = '0;
        m_inv_cell = 16'd256;
        m_off_x = '0;
        m_off_y = '0;
        m_res = 3'd3;
        m_log2_base = '0;
        foreach (cover_map[l, h])
            cover_map[l][h] = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults, extremes, clamps, clear
        v0 = '0;
        dir_rows.insert(dir_rows.size(), mk_known(FUNC_TEST, 16'd0, 16'd0, 8'sd0, 4'b1000));
        dir_rows.insert(dir_rows.size(), mk_known(FUNC_TEST, 16'd0, 16'd0, 8'sd0, 4'b0000));
        dir_rows.insert(dir_rows.size(), mk_known(FUNC_CLEAR, 16'hffff, 16'hffff, 8'h7f, v0));
        dir_rows.insert(dir_rows.size(), mk_known(FUNC_TEST, 16'd0, 16'd0, 8'sd0, 4'b1000));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'hffff, 16'hffff, 8'sd127));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'hffff, 16'd0, 8'h80));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'd0, 16'hffff, 8'sd48));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'h0100, 16'h0100, 8'sd16));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'h0150, 16'h0150, 8'sd32));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'h5555, 16'haaaa, 8'h55));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'haaaa, 16'h5555, 8'haa));
        dir_rows.insert(dir_rows.size(), mk(FUNC_CLEAR, 16'd0, 16'd0, 8'sd0));
        dir_rows.insert(dir_rows.size(), mk(FUNC_TEST, 16'h0380, 16'h0380, 8'sd15));
        foreach (dir_rows[k])
            send_feature(dir_rows[k]);

        set_config(16'hffff, 24'h7fffff, 24'h800000, 3'd7, 8'h7f);
        for (int k = 0; k < 8; k++)
            send_feature(rand_feature(k[0]));
        set_config(16'd1, 24'h800000, 24'h7fffff, 3'd0, 8'h80);
        for (int k = 0; k < 8; k++)
            send_feature(rand_feature(k[0]));

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 10;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 3)
                0: set_config(16'd256, 24'd0, 24'd0, 3'd3, 8'd0);
                1: set_config(16'($urandom_range(64, 1024)), 24'($urandom_range(0, 4096)),
                              24'(-$urandom_range(0, 4096)), 3'($urandom_range(1, 7)),
                              8'($urandom_range(0, 255)));
                default: set_config(16'($urandom), 24'($urandom), 24'($urandom),
                                    3'($urandom), 8'($urandom));
            endcase
            if (ph == 3)
            begin
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (400)
                            @(posedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 185; k++)
            begin
                send_feature(rand_feature($urandom_range(3) != 0));
                if (k == 90)
                    wait_empty();
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/dmns_pkg.sv
rtl/dmns_if.sv
rtl/dmns_ram.sv
rtl/dmns_cell_calc.sv
rtl/disk_mask_nonmax_suppressor.sv
tb/tb_disk_mask_nonmax_suppressor.sv
